// File: rtl/idbf_pkg.sv
package idbf_pkg;

    // Field and register widths.
    localparam int LevelW   = 8;
    localparam int CmdW     = 2;
    localparam int ModeW    = 3;
    localparam int IdleW    = 20;
    localparam int IntervW  = 16;
    localparam int StepsW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 20;
    localparam int DeltaW   = 9;
    localparam int PosW     = 10;
    localparam int DivCntW  = 3;
    localparam int StateW   = 3;

    // Input commands.
    localparam logic [CmdW-1:0] CMD_TICK     = 2'd0;
    localparam logic [CmdW-1:0] CMD_ACTIVITY = 2'd1;
    localparam logic [CmdW-1:0] CMD_READBACK = 2'd2;
    localparam logic [CmdW-1:0] CMD_START    = 2'd3;

    // Reported modes.
    localparam logic [ModeW-1:0] MODE_ACTIVE    = 3'd0;
    localparam logic [ModeW-1:0] MODE_FADE_DOWN = 3'd1;
    localparam logic [ModeW-1:0] MODE_FADE_UP   = 3'd2;
    localparam logic [ModeW-1:0] MODE_DIMMED    = 3'd3;
    localparam logic [ModeW-1:0] MODE_USER_OFF  = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_MAX_LEVEL      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DIM_LEVEL      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INITIAL_TARGET = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_FADE_STEPS     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_FADE_INTERVAL  = 3'd5;

    // Configuration values after reset.
    localparam logic [LevelW-1:0]  RST_MAX_LEVEL      = 8'd100;
    localparam logic [LevelW-1:0]  RST_DIM_LEVEL      = 8'd0;
    localparam logic [LevelW-1:0]  RST_INITIAL_TARGET = 8'd50;
    localparam logic [IdleW-1:0]   RST_IDLE_TIMEOUT   = 20'd5000;
    localparam logic [StepsW-1:0]  RST_FADE_STEPS     = 8'd10;
    localparam logic [IntervW-1:0] RST_FADE_INTERVAL  = 16'd50;

    // Sequencer states.
    localparam logic [StateW-1:0] ST_IDLE  = 3'd0;
    localparam logic [StateW-1:0] ST_EXEC  = 3'd1;
    localparam logic [StateW-1:0] ST_CHK   = 3'd2;
    localparam logic [StateW-1:0] ST_FS    = 3'd3;
    localparam logic [StateW-1:0] ST_DIV   = 3'd4;
    localparam logic [StateW-1:0] ST_DELTA = 3'd5;
    localparam logic [StateW-1:0] ST_STEP  = 3'd6;
    localparam logic [StateW-1:0] ST_DONE  = 3'd7;

    // Clamp a signed running position to [0, max_level].
    function automatic logic [LevelW-1:0] clamp_level(
        input logic signed [PosW-1:0] v,
        input logic [LevelW-1:0]      max_lvl
    );
        logic signed [PosW-1:0] max_s;
        max_s = signed'({{(PosW-LevelW){1'b0}}, max_lvl});
        if (v < 0) begin
            return '0;
        end else if (v > max_s) begin
            return max_lvl;
        end else begin
            return v[LevelW-1:0];
        end
    endfunction

endpackage

// File: rtl/idle_dimming_backlight_fader_core.sv
// An accepted transaction runs through the command state and, when a fade starts, the
// fade start, bit-serial divider, delta and step states before the result is loaded;
// held activity that ends its fade at once can see the idle timeout start a second fade.
// A new transaction is taken only in the idle state and when the result register is free.
// Reset: i_rst_n is synchronous and active low; it clears all state and loads the
// configuration defaults. There is no clearing pass.
module idle_dimming_backlight_fader_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [idbf_pkg::CmdW-1:0]      i_cmd,
    input  logic [idbf_pkg::LevelW-1:0]    i_readback_level,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_write_valid,
    output logic [idbf_pkg::LevelW-1:0]    o_level_out,
    output logic [idbf_pkg::ModeW-1:0]     o_mode,
    // Configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [idbf_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [idbf_pkg::CfgDataW-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [idbf_pkg::LevelW-1:0]  r_max_level;
    logic [idbf_pkg::LevelW-1:0]  r_dim_level;
    logic [idbf_pkg::LevelW-1:0]  r_initial_target;
    logic [idbf_pkg::IdleW-1:0]   r_idle_timeout;
    logic [idbf_pkg::StepsW-1:0]  r_fade_steps;
    logic [idbf_pkg::IntervW-1:0] r_fade_interval;

    // Sequencer and latched transaction.
    logic [idbf_pkg::StateW-1:0]  r_state;
    logic [idbf_pkg::CmdW-1:0]    r_cmd;
    logic [idbf_pkg::LevelW-1:0]  r_rb;
    logic                         r_chk_next;
    logic [idbf_pkg::LevelW-1:0]  r_req_goal;

    // Fader state.
    logic [idbf_pkg::LevelW-1:0]        r_level;
    logic [idbf_pkg::LevelW-1:0]        r_last_written;
    logic                               r_lw_known;
    logic [idbf_pkg::LevelW-1:0]        r_active_target;
    logic [idbf_pkg::IdleW-1:0]         r_idle_count;
    logic                               r_dimmed;
    logic                               r_user_off;
    logic                               r_fade_active;
    logic [idbf_pkg::LevelW-1:0]        r_fade_goal;
    logic signed [idbf_pkg::DeltaW-1:0] r_fade_delta;
    logic [idbf_pkg::IntervW-1:0]       r_fade_timer;
    logic                               r_act_pending;
    logic signed [idbf_pkg::PosW-1:0]   r_fade_pos;
    logic                               r_wrote;

    // Serial divider.
    logic [idbf_pkg::LevelW-1:0]  r_div_rem;
    logic [idbf_pkg::LevelW-1:0]  r_div_quo;
    logic [idbf_pkg::DivCntW-1:0] r_div_cnt;
    logic                         r_div_neg;

    // Output register.
    logic                         r_out_valid;
    logic                         r_out_write;
    logic [idbf_pkg::LevelW-1:0]  r_out_level;
    logic [idbf_pkg::ModeW-1:0]   r_out_mode;

    // Combinational helpers.
    logic                               in_fire;
    logic [idbf_pkg::LevelW-1:0]        steps_eff;
    logic [idbf_pkg::IntervW-1:0]       interval_eff;
    logic signed [idbf_pkg::DeltaW-1:0] fade_span;
    logic [idbf_pkg::LevelW:0]          rem_sh;
    logic                               rem_ge;
    logic signed [idbf_pkg::DeltaW-1:0] quo_s;
    logic signed [idbf_pkg::PosW-1:0]   pos_n;
    logic signed [idbf_pkg::PosW-1:0]   goal_s;
    logic                               reached;
    logic signed [idbf_pkg::PosW-1:0]   put_val;
    logic [idbf_pkg::LevelW-1:0]        put_lvl;
    logic                               put_change;
    logic [idbf_pkg::IntervW-1:0]       timer_dec;
    logic [idbf_pkg::ModeW-1:0]         mode_now;

    assign in_fire      = i_in_valid && o_in_ready;
    assign o_in_ready   = (r_state == idbf_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready  = 1'b1;
    assign steps_eff    = (r_fade_steps == '0) ? 8'd1 : r_fade_steps;
    assign interval_eff = (r_fade_interval == '0) ? 16'd1 : r_fade_interval;

    // Signed distance from the current level to the requested goal.
    assign fade_span = signed'({1'b0, r_req_goal}) - signed'({1'b0, r_level});

    // One restoring division step.
    assign rem_sh = {r_div_rem, r_div_quo[idbf_pkg::LevelW-1]};
    assign rem_ge = (rem_sh >= {1'b0, steps_eff});
    assign quo_s  = signed'({1'b0, r_div_quo});

    // Fade step: advance the position and test whether the goal is reached or passed.
    assign goal_s  = signed'({{(idbf_pkg::PosW-idbf_pkg::LevelW){1'b0}}, r_fade_goal});
    assign pos_n   = r_fade_pos + idbf_pkg::PosW'(r_fade_delta);
    assign reached = (r_fade_delta > 0) ? (pos_n >= goal_s) : (pos_n <= goal_s);

    // Level write path, shared by the start command and the fade step.
    always_comb begin
        if (r_state == idbf_pkg::ST_STEP) begin
            put_val = reached ? goal_s : pos_n;
        end else begin
            put_val = signed'({{(idbf_pkg::PosW-idbf_pkg::LevelW){1'b0}}, r_initial_target});
        end
    end
    assign put_lvl    = idbf_pkg::clamp_level(put_val, r_max_level);
    assign put_change = (put_lvl != r_level);

    assign timer_dec = (r_fade_timer != '0) ? (r_fade_timer - 16'd1) : '0;

    // Mode as seen after the transaction.
    always_comb begin
        if (r_fade_active) begin
            mode_now = (r_fade_delta < 0) ? idbf_pkg::MODE_FADE_DOWN : idbf_pkg::MODE_FADE_UP;
        end else if (r_user_off) begin
            mode_now = idbf_pkg::MODE_USER_OFF;
        end else if (r_dimmed) begin
            mode_now = idbf_pkg::MODE_DIMMED;
        end else begin
            mode_now = idbf_pkg::MODE_ACTIVE;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level      <= idbf_pkg::RST_MAX_LEVEL;
            r_dim_level      <= idbf_pkg::RST_DIM_LEVEL;
            r_initial_target <= idbf_pkg::RST_INITIAL_TARGET;
            r_idle_timeout   <= idbf_pkg::RST_IDLE_TIMEOUT;
            r_fade_steps     <= idbf_pkg::RST_FADE_STEPS;
            r_fade_interval  <= idbf_pkg::RST_FADE_INTERVAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                idbf_pkg::REG_MAX_LEVEL:      r_max_level      <= i_cfg_data[7:0];
                idbf_pkg::REG_DIM_LEVEL:      r_dim_level      <= i_cfg_data[7:0];
                idbf_pkg::REG_INITIAL_TARGET: r_initial_target <= i_cfg_data[7:0];
                idbf_pkg::REG_IDLE_TIMEOUT:   r_idle_timeout   <= i_cfg_data;
                idbf_pkg::REG_FADE_STEPS:     r_fade_steps     <= i_cfg_data[7:0];
                idbf_pkg::REG_FADE_INTERVAL:  r_fade_interval  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= idbf_pkg::ST_IDLE;
            r_cmd           <= idbf_pkg::CMD_TICK;
            r_rb            <= '0;
            r_chk_next      <= 1'b0;
            r_req_goal      <= '0;
            r_level         <= '0;
            r_last_written  <= '0;
            r_lw_known      <= 1'b0;
            r_active_target <= '0;
            r_idle_count    <= '0;
            r_dimmed        <= 1'b0;
            r_user_off      <= 1'b0;
            r_fade_active   <= 1'b0;
            r_fade_goal     <= '0;
            r_fade_delta    <= '0;
            r_fade_timer    <= '0;
            r_act_pending   <= 1'b0;
            r_fade_pos      <= '0;
            r_wrote         <= 1'b0;
            r_div_rem       <= '0;
            r_div_quo       <= '0;
            r_div_cnt       <= '0;
            r_div_neg       <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_write     <= 1'b0;
            r_out_level     <= '0;
            r_out_mode      <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                idbf_pkg::ST_IDLE: begin
                    if (in_fire) begin
                        r_cmd   <= i_cmd;
                        r_rb    <= i_readback_level;
                        r_wrote <= 1'b0;
                        r_state <= idbf_pkg::ST_EXEC;
                    end
                end

                // Apply the command itself.
                idbf_pkg::ST_EXEC: begin
                    r_state <= idbf_pkg::ST_DONE;
                    case (r_cmd)
                        idbf_pkg::CMD_TICK: begin
                            if (r_fade_active) begin
                                if (r_idle_count != '1) begin
                                    r_idle_count <= r_idle_count + 20'd1;
                                end
                                r_fade_timer <= timer_dec;
                                if (timer_dec == '0) begin
                                    r_state <= idbf_pkg::ST_STEP;
                                end
                            end else if (r_act_pending) begin
                                // Held activity is applied now; it clears the idle count.
                                r_act_pending <= 1'b0;
                                r_idle_count  <= '0;
                                if (r_dimmed && !r_user_off) begin
                                    r_dimmed   <= 1'b0;
                                    r_req_goal <= r_active_target;
                                    r_chk_next <= 1'b1;
                                    r_state    <= idbf_pkg::ST_FS;
                                end else begin
                                    r_state <= idbf_pkg::ST_CHK;
                                end
                            end else begin
                                if (r_idle_count != '1) begin
                                    r_idle_count <= r_idle_count + 20'd1;
                                end
                                r_state <= idbf_pkg::ST_CHK;
                            end
                        end
                        idbf_pkg::CMD_ACTIVITY: begin
                            if (r_fade_active) begin
                                r_act_pending <= 1'b1;
                            end else begin
                                r_idle_count <= '0;
                                if (r_dimmed && !r_user_off) begin
                                    r_dimmed   <= 1'b0;
                                    r_req_goal <= r_active_target;
                                    r_chk_next <= 1'b0;
                                    r_state    <= idbf_pkg::ST_FS;
                                end
                            end
                        end
                        idbf_pkg::CMD_READBACK: begin
                            // A differing readback is adopted as the level.
                            if (!r_fade_active && r_lw_known && r_rb != r_last_written) begin
                                r_level        <= r_rb;
                                r_last_written <= r_rb;
                                r_dimmed       <= 1'b0;
                                if (r_rb != '0) begin
                                    r_active_target <= r_rb;
                                    r_idle_count    <= '0;
                                    r_user_off      <= 1'b0;
                                end else begin
                                    r_user_off <= 1'b1;
                                end
                            end
                        end
                        idbf_pkg::CMD_START: begin
                            r_fade_active   <= 1'b0;
                            r_act_pending   <= 1'b0;
                            r_active_target <= r_initial_target;
                            r_idle_count    <= '0;
                            r_dimmed        <= 1'b0;
                            r_user_off      <= 1'b0;
                            if (put_change) begin
                                r_level        <= put_lvl;
                                r_last_written <= put_lvl;
                                r_lw_known     <= 1'b1;
                                r_wrote        <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end

                // Idle timeout check.
                idbf_pkg::ST_CHK: begin
                    r_chk_next <= 1'b0;
                    if (!r_fade_active && !r_dimmed && !r_user_off &&
                        r_idle_count >= r_idle_timeout) begin
                        r_dimmed   <= 1'b1;
                        r_req_goal <= r_dim_level;
                        r_state    <= idbf_pkg::ST_FS;
                    end else begin
                        r_state <= idbf_pkg::ST_DONE;
                    end
                end

                // Fade start: no fade when already at the goal.
                idbf_pkg::ST_FS: begin
                    if (fade_span == '0) begin
                        r_state <= r_chk_next ? idbf_pkg::ST_CHK : idbf_pkg::ST_DONE;
                    end else begin
                        r_fade_goal   <= r_req_goal;
                        r_fade_pos    <= signed'({2'b00, r_level});
                        r_fade_active <= 1'b1;
                        r_div_neg     <= fade_span[idbf_pkg::DeltaW-1];
                        r_div_quo     <= fade_span[idbf_pkg::DeltaW-1] ?
                                         idbf_pkg::LevelW'(-fade_span) :
                                         fade_span[idbf_pkg::LevelW-1:0];
                        r_div_rem     <= '0;
                        r_div_cnt     <= '1;
                        r_state       <= idbf_pkg::ST_DIV;
                    end
                end

                // Restoring division of the distance magnitude, one bit a cycle.
                idbf_pkg::ST_DIV: begin
                    r_div_rem <= rem_ge ? idbf_pkg::LevelW'(rem_sh - {1'b0, steps_eff})
                                        : rem_sh[idbf_pkg::LevelW-1:0];
                    r_div_quo <= {r_div_quo[idbf_pkg::LevelW-2:0], rem_ge};
                    r_div_cnt <= r_div_cnt - 3'd1;
                    if (r_div_cnt == '0) begin
                        r_state <= idbf_pkg::ST_DELTA;
                    end
                end

                // Signed delta, of magnitude at least one.
                idbf_pkg::ST_DELTA: begin
                    if (r_div_quo == '0) begin
                        r_fade_delta <= r_div_neg ? -9'sd1 : 9'sd1;
                    end else begin
                        r_fade_delta <= r_div_neg ? -quo_s : quo_s;
                    end
                    r_state <= idbf_pkg::ST_STEP;
                end

                // One fade step; after held activity the timeout is checked as well.
                idbf_pkg::ST_STEP: begin
                    r_fade_pos <= pos_n;
                    if (reached) begin
                        r_fade_active <= 1'b0;
                    end else begin
                        r_fade_timer <= interval_eff;
                    end
                    if (put_change) begin
                        r_level        <= put_lvl;
                        r_last_written <= put_lvl;
                        r_lw_known     <= 1'b1;
                        r_wrote        <= 1'b1;
                    end
                    r_state <= r_chk_next ? idbf_pkg::ST_CHK : idbf_pkg::ST_DONE;
                end

                // Load the result register.
                idbf_pkg::ST_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_write <= r_wrote;
                    r_out_level <= r_level;
                    r_out_mode  <= mode_now;
                    r_state     <= idbf_pkg::ST_IDLE;
                end

                default: r_state <= idbf_pkg::ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_valid = r_out_write;
    assign o_level_out   = r_out_level;
    assign o_mode        = r_out_mode;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import idbf_pkg::*;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic              wr;
        logic [LevelW-1:0] level;
        logic [ModeW-1:0]  mode;
    } fader_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // A directed row is either an input transaction or a register write.
    typedef struct {
        row_kind_e     kind;
        logic [2:0]    sel;
        int            value;
        bit            typed;
        fader_result_t res;
    } script_row_t;

    localparam int ScriptLen    = 37;
    localparam int PhaseCount   = 10;
    localparam int PhaseItems   = 50;
    localparam int SettleCycles = 20;
    localparam int ReportLimit  = 10;
    localparam int IdleMax      = (1 << IdleW) - 1;
    localparam fader_result_t NoResult = '0;

    // Block ports.
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [CmdW-1:0]     i_cmd            = CMD_TICK;
    logic [LevelW-1:0]   i_readback_level = '0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    logic                o_write_valid;
    logic [LevelW-1:0]   o_level_out;
    logic [ModeW-1:0]    o_mode;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index      = REG_MAX_LEVEL;
    logic [CfgDataW-1:0] i_cfg_data       = '0;

    // Idle rates of the two sides, in percent of cycles.
    int in_gap_pct    = 13;
    int out_stall_pct = 58;

    fader_result_t expected_levels[$];
    int            mismatches = 0;
    script_row_t   script [ScriptLen];

    // Mirror of the configuration registers.
    int cf_max      = RST_MAX_LEVEL;
    int cf_dim      = RST_DIM_LEVEL;
    int cf_init     = RST_INITIAL_TARGET;
    int cf_timeout  = RST_IDLE_TIMEOUT;
    int cf_steps    = RST_FADE_STEPS;
    int cf_interval = RST_FADE_INTERVAL;

    // Mirror of the fader state; all of it is zero after reset.
    int st_level  = 0;
    int st_last   = 0;
    int st_target = 0;
    int st_idle   = 0;
    int st_goal   = 0;
    int st_delta  = 0;
    int st_timer  = 0;
    int st_pos    = 0;
    bit st_known   = 1'b0;
    bit st_dimmed  = 1'b0;
    bit st_user_off = 1'b0;
    bit st_fading  = 1'b0;
    bit st_pending = 1'b0;
    bit st_wrote   = 1'b0;

    idle_dimming_backlight_fader_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_readback_level (i_readback_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_valid    (o_write_valid),
        .o_level_out      (o_level_out),
        .o_mode           (o_mode),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Clamp to [0, max] and write only when the level actually changes.
    function automatic void drive_level(input int v);
        int c;
        if (v < 0) begin
            c = 0;
        end else if (v > cf_max) begin
            c = cf_max;
        end else begin
            c = v;
        end
        if (c != st_level) begin
            st_level = c;
            st_last  = c;
            st_known = 1'b1;
            st_wrote = 1'b1;
        end
    endfunction

    // One fade step; the fade ends once the position reaches or passes the goal.
    function automatic void fade_advance();
        st_pos += st_delta;
        if ((st_delta > 0 && st_pos >= st_goal) || (st_delta < 0 && st_pos <= st_goal)) begin
            drive_level(st_goal);
            st_fading = 1'b0;
        end else begin
            drive_level(st_pos);
            st_timer = (cf_interval != 0) ? cf_interval : 1;
        end
    endfunction

    // Work out the step size and take the first step at once.
    function automatic void fade_begin(input int goal);
        int span;
        int divisor;
        span    = goal - st_level;
        divisor = (cf_steps != 0) ? cf_steps : 1;
        if (span != 0) begin
            st_delta = span / divisor;
            if (st_delta == 0) begin
                st_delta = (span > 0) ? 1 : -1;
            end
            st_goal   = goal;
            st_pos    = st_level;
            st_fading = 1'b1;
            fade_advance();
        end
    endfunction

    // User activity outside a fade: clear the idle count and undim.
    function automatic void wake_up();
        st_idle = 0;
        if (st_dimmed && !st_user_off) begin
            st_dimmed = 1'b0;
            fade_begin(st_target);
        end
    endfunction

    // Expected result of one input transaction; advances the mirrored state.
    function automatic fader_result_t predict_backlight(input logic [CmdW-1:0] c, input int rb);
        fader_result_t r;
        st_wrote = 1'b0;
        case (c)
            CMD_TICK: begin
                if (st_idle < IdleMax) begin
                    st_idle++;
                end
                if (st_fading) begin
                    if (st_timer > 0) begin
                        st_timer--;
                    end
                    if (st_timer == 0) begin
                        fade_advance();
                    end
                end else begin
                    if (st_pending) begin
                        st_pending = 1'b0;
                        wake_up();
                    end
                    if (!st_fading && !st_dimmed && !st_user_off && st_idle >= cf_timeout) begin
                        st_dimmed = 1'b1;
                        fade_begin(cf_dim);
                    end
                end
            end
            CMD_ACTIVITY: begin
                if (st_fading) begin
                    st_pending = 1'b1;
                end else begin
                    wake_up();
                end
            end
            CMD_READBACK: begin
                // An external change is adopted as it is, even above the maximum.
                if (!st_fading && st_known && rb != st_last) begin
                    st_level  = rb;
                    st_last   = rb;
                    st_dimmed = 1'b0;
                    if (rb > 0) begin
                        st_target   = rb;
                        st_idle     = 0;
                        st_user_off = 1'b0;
                    end else begin
                        st_user_off = 1'b1;
                    end
                end
            end
            default: begin
                st_fading   = 1'b0;
                st_pending  = 1'b0;
                st_target   = cf_init;
                st_idle     = 0;
                st_dimmed   = 1'b0;
                st_user_off = 1'b0;
                drive_level(st_target);
            end
        endcase
        r.wr    = st_wrote;
        r.level = st_level[LevelW-1:0];
        if (st_fading) begin
            r.mode = (st_delta < 0) ? MODE_FADE_DOWN : MODE_FADE_UP;
        end else if (st_user_off) begin
            r.mode = MODE_USER_OFF;
        end else if (st_dimmed) begin
            r.mode = MODE_DIMMED;
        end else begin
            r.mode = MODE_ACTIVE;
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input fader_result_t want,
                                          input fader_result_t got);
        mismatches++;
        if (mismatches <= ReportLimit) begin
            $display("[%0t] %s: expected write=%0b level=%0d mode=%0d, got write=%0b level=%0d mode=%0d",
                     $realtime, what, want.wr, want.level, want.mode, got.wr, got.level, got.mode);
        end
    endfunction

    // Present one input transaction, hold it until accepted, then maybe pause.
    task automatic send_cmd(input logic [CmdW-1:0] c, input int rb, input bit typed,
                            input fader_result_t typed_res);
        fader_result_t p;
        i_in_valid       <= 1'b1;
        i_cmd            <= c;
        i_readback_level <= rb[LevelW-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        p = predict_backlight(c, rb);
        expected_levels.push_back(typed ? typed_res : p);
        if ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_gap_pct);
        end
    endtask

    // Stop sending and wait until every expected result has been received.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CfgDataW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_LEVEL:      cf_max      = value & 'hFF;
            REG_DIM_LEVEL:      cf_dim      = value & 'hFF;
            REG_INITIAL_TARGET: cf_init     = value & 'hFF;
            REG_IDLE_TIMEOUT:   cf_timeout  = value & 'hFFFFF;
            REG_FADE_STEPS:     cf_steps    = value & 'hFF;
            REG_FADE_INTERVAL:  cf_interval = value & 'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_fader(input int max_lvl, input int dim, input int init,
                                 input int timeout, input int steps, input int interval);
        write_reg(REG_MAX_LEVEL, max_lvl);
        write_reg(REG_DIM_LEVEL, dim);
        write_reg(REG_INITIAL_TARGET, init);
        write_reg(REG_IDLE_TIMEOUT, timeout);
        write_reg(REG_FADE_STEPS, steps);
        write_reg(REG_FADE_INTERVAL, interval);
    endtask

    // Result checker; the receiver also decides its stalls here.
    always @(posedge i_clk) begin : result_monitor
        fader_result_t got;
        fader_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_write_valid, o_level_out, o_mode};
            if (expected_levels.size() == 0) begin
                note_mismatch("unexpected result", NoResult, got);
            end else begin
                want = expected_levels.pop_front();
                if (got.wr !== want.wr || got.level !== want.level || got.mode !== want.mode) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // Main stimulus: directed rows, then randomised phases under varied settings.
    initial begin : stimulus
        int n;
        int phase;
        int roll;
        int rb;
        logic [CmdW-1:0] cmd_sel;

        script = '{
            // Straight after reset: nothing written yet, so readbacks are ignored.
            '{ROW_ITEM, CMD_TICK,      0, 1'b1, '{1'b0, 8'd0,   MODE_ACTIVE}},
            '{ROW_ITEM, CMD_READBACK, 77, 1'b1, '{1'b0, 8'd0,   MODE_ACTIVE}},
            '{ROW_ITEM, CMD_ACTIVITY,  0, 1'b1, '{1'b0, 8'd0,   MODE_ACTIVE}},
            '{ROW_ITEM, CMD_START,     0, 1'b1, '{1'b1, 8'd50,  MODE_ACTIVE}},
            '{ROW_ITEM, CMD_READBACK, 50, 1'b1, '{1'b0, 8'd50,  MODE_ACTIVE}},
            // Readback above the maximum is taken unclamped; zero means switched off.
            '{ROW_ITEM, CMD_READBACK, 255, 1'b1, '{1'b0, 8'd255, MODE_ACTIVE}},
            '{ROW_ITEM, CMD_READBACK,  0, 1'b1, '{1'b0, 8'd0,   MODE_USER_OFF}},
            '{ROW_ITEM, CMD_TICK,      0, 1'b1, '{1'b0, 8'd0,   MODE_USER_OFF}},
            // Short timeout: dim, hold activity and ignore readback during the fade.
            '{ROW_CFG,  REG_IDLE_TIMEOUT,  2, 1'b0, NoResult},
            '{ROW_CFG,  REG_FADE_INTERVAL, 1, 1'b0, NoResult},
            '{ROW_CFG,  REG_FADE_STEPS,    2, 1'b0, NoResult},
            '{ROW_ITEM, CMD_START,     0, 1'b1, '{1'b1, 8'd50,  MODE_ACTIVE}},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_ACTIVITY,  0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_READBACK,  9, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            // Zero maximum, zero step count and zero interval.
            '{ROW_CFG,  REG_MAX_LEVEL,       0, 1'b0, NoResult},
            '{ROW_CFG,  REG_FADE_STEPS,      0, 1'b0, NoResult},
            '{ROW_CFG,  REG_FADE_INTERVAL,   0, 1'b0, NoResult},
            '{ROW_CFG,  REG_INITIAL_TARGET, 255, 1'b0, NoResult},
            '{ROW_ITEM, CMD_START,     0, 1'b1, '{1'b1, 8'd0,   MODE_ACTIVE}},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_ACTIVITY,  0, 1'b0, NoResult},
            // Target above the maximum: the written level stays clamped.
            '{ROW_CFG,  REG_MAX_LEVEL,     100, 1'b0, NoResult},
            '{ROW_CFG,  REG_INITIAL_TARGET, 200, 1'b0, NoResult},
            '{ROW_CFG,  REG_FADE_STEPS,      3, 1'b0, NoResult},
            '{ROW_CFG,  REG_FADE_INTERVAL,   2, 1'b0, NoResult},
            '{ROW_CFG,  REG_IDLE_TIMEOUT,    1, 1'b0, NoResult},
            '{ROW_ITEM, CMD_START,     0, 1'b1, '{1'b1, 8'd100, MODE_ACTIVE}},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_TICK,      0, 1'b0, NoResult},
            '{ROW_ITEM, CMD_ACTIVITY,  0, 1'b0, NoResult}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < ScriptLen; n++) begin
            if (script[n].kind == ROW_CFG) begin
                settle();
                write_reg(script[n].sel, script[n].value);
            end else begin
                send_cmd(script[n].sel[CmdW-1:0], script[n].value, script[n].typed,
                         script[n].res);
            end
        end

        for (phase = 0; phase < PhaseCount; phase++) begin
            // Swap the idle rates part way through, then run without idling.
            if (phase == 4) begin
                in_gap_pct    = 58;
                out_stall_pct = 13;
            end else if (phase == 7) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            settle();
            case (phase)
                0: program_fader(255, 0, 255, 5, 1, 1);
                1: program_fader(1, 0, 1, 3, 255, 2);
                2: program_fader(200, 30, 150, 0, 7, 3);
                3: program_fader(128, 255, 0, 10, 4, 1);
                4: program_fader(255, 255, 255, IdleMax, 255, 65535);
                5: program_fader(60, 5, 40, 2, 10, 1);
                default: program_fader($urandom_range(1, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 20),
                                       $urandom_range(1, 255), $urandom_range(1, 4));
            endcase
            for (n = 0; n < PhaseItems; n++) begin
                // Once, let the sender wait until the result queue is empty.
                if (phase == 2 && n == PhaseItems / 2) begin
                    settle();
                end
                // Mostly ticks, so that timeouts and fades run their course.
                roll = $urandom_range(0, 99);
                rb   = 0;
                if (roll < 62) begin
                    cmd_sel = CMD_TICK;
                end else if (roll < 74) begin
                    cmd_sel = CMD_ACTIVITY;
                end else if (roll < 88) begin
                    cmd_sel = CMD_READBACK;
                    case ($urandom_range(0, 3))
                        0: rb = st_last;
                        1: rb = 0;
                        2: rb = cf_max;
                        default: rb = $urandom_range(0, 255);
                    endcase
                end else begin
                    cmd_sel = CMD_START;
                    rb      = $urandom_range(0, 255);
                end
                send_cmd(cmd_sel, rb, 1'b0, NoResult);
            end
        end

        settle();
        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/idbf_pkg.sv
rtl/idle_dimming_backlight_fader_core.sv
tb/tb_top.sv
